// ----- hdl/ophf_pkg.sv -----
// ----------------------------------------------------------------------------
// ophf_pkg
// Shared constants, types and register codes of the oil-paint histogram filter.
// ----------------------------------------------------------------------------
package ophf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int RING_SIZE  = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
    localparam int RING_AW    = $clog2(RING_SIZE);

    localparam int FW_W   = 11;
    localparam int FH_W   = 16;
    localparam int RAD_W  = 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int LAG_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int DC_W   = $clog2(2 * MAX_RADIUS + 1);

    localparam int COLOR_W    = 8;
    localparam int NCOL       = 3;
    localparam int PIX_W      = NCOL * COLOR_W;
    localparam int MAX_WIN    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W      = $clog2(MAX_WIN + 1);
    localparam int SUM_W      = 14;
    localparam int INT_W      = 8;
    localparam int HIST_DEPTH = 256;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam int K_R      = 21;
    localparam int K_G      = 72;
    localparam int K_B      = 7;
    localparam int X_W      = 15;
    localparam int RECIP    = 5243;
    localparam int RECIP_W  = 13;
    localparam int RECIP_SH = 19;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [FW_W-1:0]  RST_WIDTH  = FW_W'(640);
    localparam logic [FH_W-1:0]  RST_HEIGHT = FH_W'(480);
    localparam logic [RAD_W-1:0] RST_RADIUS = RAD_W'(2);

    typedef struct packed {
        logic accept;
        logic wstart;
        logic pint;
        logic pdiv;
        logic hwr;
        logic dstart;
        logic dstep;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic interior;
        logic win_last;
        logic div_last;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
    } t_hist;

endpackage

// ----- hdl/ophf_in_if.sv -----
// ----------------------------------------------------------------------------
// ophf_in_if
// Input channel: one pixel or flush item per handshake.
// ----------------------------------------------------------------------------
interface ophf_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, kind, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

// ----- hdl/ophf_out_if.sv -----
// ----------------------------------------------------------------------------
// ophf_out_if
// Output channel: one filtered pixel per handshake.
// ----------------------------------------------------------------------------
interface ophf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ----- hdl/oil_paint_histogram_filter.sv -----
// ----------------------------------------------------------------------------
// oil_paint_histogram_filter
// Oil-paint filter over a raster RGB stream with an APB register port.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and leave radius rows plus radius pixels later;
// flush items drain the held tail. An item is taken only when the sequencer is
// idle, while the previous result may still wait in the output register. An
// item that emits a border pixel goes through a copy state; an interior pixel
// goes through a pass of line-ring read, intensity and histogram read-modify-
// write for each window pixel, followed by a bit-serial division. Any register
// write restarts the stream.
// ----------------------------------------------------------------------------
module oil_paint_histogram_filter import ophf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    ophf_in_if.sink           i_pix,
    ophf_out_if.source        o_pix
);

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [RAD_W-1:0] r_window_radius;

    logic             wr_en;
    logic [1:0]       reg_idx;
    logic             restart;
    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [RAD_W-1:0] rad_eff;
    t_cmd             cmd;
    t_stat            stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign restart = wr_en && ((reg_idx == REG_WIDTH) || (reg_idx == REG_HEIGHT) ||
                               (reg_idx == REG_RADIUS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= RST_WIDTH;
            r_frame_height  <= RST_HEIGHT;
            r_window_radius <= RST_RADIUS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:  r_frame_width   <= pwdata[FW_W-1:0];
                REG_HEIGHT: r_frame_height  <= pwdata[FH_W-1:0];
                REG_RADIUS: r_window_radius <= pwdata[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = DATA_W'(r_frame_width);
            REG_HEIGHT: prdata = DATA_W'(r_frame_height);
            REG_RADIUS: prdata = DATA_W'(r_window_radius);
            default:    prdata = '0;
        endcase
    end

    assign w_eff = (r_frame_width == '0) ? FW_W'(1) :
                   ((r_frame_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : r_frame_width);
    assign h_eff = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    assign rad_eff = (int'(r_window_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                         : r_window_radius;

    ophf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ophf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_restart   (restart),
        .i_w         (w_eff),
        .i_h         (h_eff),
        .i_rad       (rad_eff),
        .i_kind      (i_pix.kind),
        .i_red       (i_pix.red_in),
        .i_green     (i_pix.green_in),
        .i_blue      (i_pix.blue_in),
        .i_out_ready (o_pix.ready),
        .o_stat      (stat),
        .o_out_valid (o_pix.valid),
        .o_red       (o_pix.red_out),
        .o_green     (o_pix.green_out),
        .o_blue      (o_pix.blue_out),
        .o_fend      (o_pix.frame_end)
    );

endmodule

// ----- hdl/ophf_ctrl.sv -----
// ----------------------------------------------------------------------------
// ophf_ctrl
// Sequencer of the filter: border copy, window scan, mode search, division.
// ----------------------------------------------------------------------------
module ophf_ctrl import ophf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BRD    = 4'd1;
    localparam logic [3:0] S_WSTART = 4'd2;
    localparam logic [3:0] S_PRD    = 4'd3;
    localparam logic [3:0] S_PINT   = 4'd4;
    localparam logic [3:0] S_PDIV   = 4'd5;
    localparam logic [3:0] S_HRD    = 4'd6;
    localparam logic [3:0] S_HWR    = 4'd7;
    localparam logic [3:0] S_DSTART = 4'd8;
    localparam logic [3:0] S_DSTEP  = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.emit) begin
                        n_state = i_stat.interior ? S_WSTART : S_BRD;
                    end
                end
            end
            S_BRD: begin
                n_state = S_FINISH;
            end
            S_WSTART: begin
                o_cmd.wstart = 1'b1;
                n_state      = S_PRD;
            end
            S_PRD: begin
                n_state = S_PINT;
            end
            S_PINT: begin
                o_cmd.pint = 1'b1;
                n_state    = S_PDIV;
            end
            S_PDIV: begin
                o_cmd.pdiv = 1'b1;
                n_state    = S_HRD;
            end
            S_HRD: begin
                n_state = S_HWR;
            end
            S_HWR: begin
                o_cmd.hwr = 1'b1;
                n_state   = i_stat.win_last ? S_DSTART : S_PRD;
            end
            S_DSTART: begin
                o_cmd.dstart = 1'b1;
                n_state      = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.dstep = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/ophf_dpath.sv -----
// ----------------------------------------------------------------------------
// ophf_dpath
// Line ring, stream counters, intensity histogram, dividers and output register.
// ----------------------------------------------------------------------------
module ophf_dpath import ophf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_restart,
    input  logic [FW_W-1:0]    i_w,
    input  logic [FH_W-1:0]    i_h,
    input  logic [RAD_W-1:0]   i_rad,
    input  logic               i_kind,
    input  logic [COLOR_W-1:0] i_red,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_blue,
    input  logic               i_out_ready,
    output t_stat              o_stat,
    output logic               o_out_valid,
    output logic [COLOR_W-1:0] o_red,
    output logic [COLOR_W-1:0] o_green,
    output logic [COLOR_W-1:0] o_blue,
    output logic               o_fend
);

    logic [PIX_W-1:0]   r_ring [RING_SIZE];
    logic [PIX_W-1:0]   r_rdata;
    logic [RING_AW-1:0] r_wp;
    logic [LAG_W-1:0]   r_held;
    logic [COL_W-1:0]   r_ocol;
    logic [FH_W-1:0]    r_orow;
    logic [RING_AW-1:0] r_raddr;
    logic [RING_AW-1:0] r_rowb;
    logic               r_border;
    logic               r_fend;
    logic [DC_W-1:0]    r_dc;
    logic [DC_W-1:0]    r_dr;
    logic [PIX_W-1:0]   r_rgb;
    logic [X_W-1:0]     r_x;
    logic [INT_W-1:0]   r_inten;
    t_hist              r_hist [HIST_DEPTH];
    t_hist              r_hdata;
    logic               r_hv;
    logic [HIST_DEPTH-1:0] r_hvalid;
    logic [CNT_W-1:0]   r_best_cnt;
    logic [INT_W-1:0]   r_best_int;
    logic [SUM_W-1:0]   r_best_sum [NCOL];
    logic [SUM_W-1:0]   r_divd [NCOL];
    logic [CNT_W-1:0]   r_rem [NCOL];
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_col [NCOL];
    logic               r_out_fend;

    logic [LAG_W-1:0]    lag;
    logic [LAG_W:0]      held_inc;
    logic                emit;
    logic [RING_AW:0]    pos_raw;
    logic [RING_AW-1:0]  pos;
    logic [FW_W-1:0]     col_hi;
    logic [FW_W-1:0]     col_inc;
    logic [FH_W:0]       row_hi;
    logic [FH_W:0]       row_inc;
    logic                interior;
    logic                fend;
    logic [RING_AW:0]    rb_raw;
    logic [RING_AW-1:0]  rb;
    logic [RING_AW:0]    rowb_sum;
    logic [RING_AW-1:0]  rowb_next;
    logic [RING_AW-1:0]  addr_next;
    logic [DC_W-1:0]     two_r;
    logic [X_W+RECIP_W-1:0] prod;
    logic [CNT_W-1:0]    cnt_new;
    logic [SUM_W-1:0]    sum_new [NCOL];
    logic [SUM_W-1:0]    sum_old [NCOL];
    logic                take_best;
    logic [CNT_W:0]      trial [NCOL];
    logic                ge [NCOL];

    assign lag      = LAG_W'(LAG_W'(i_rad) * LAG_W'(i_w) + LAG_W'(i_rad));
    assign held_inc = (LAG_W+1)'(r_held) + 1'b1;
    assign emit     = i_kind ? (r_held != '0) : (held_inc > (LAG_W+1)'(lag));
    assign pos_raw  = (RING_AW+1)'(r_wp) - (RING_AW+1)'(r_held);
    assign pos      = pos_raw[RING_AW] ? RING_AW'(pos_raw + (RING_AW+1)'(RING_SIZE))
                                       : RING_AW'(pos_raw);

    assign col_hi   = FW_W'(r_ocol) + FW_W'(i_rad);
    assign col_inc  = FW_W'(r_ocol) + 1'b1;
    assign row_hi   = (FH_W+1)'(r_orow) + (FH_W+1)'(i_rad);
    assign row_inc  = (FH_W+1)'(r_orow) + 1'b1;
    assign interior = (r_ocol >= COL_W'(i_rad)) && (col_hi < i_w) &&
                      (r_orow >= FH_W'(i_rad)) && (row_hi < (FH_W+1)'(i_h));
    assign fend     = (row_inc == (FH_W+1)'(i_h)) && (col_inc == i_w);

    assign rb_raw    = (RING_AW+1)'(r_raddr) - (RING_AW+1)'(lag);
    assign rb        = rb_raw[RING_AW] ? RING_AW'(rb_raw + (RING_AW+1)'(RING_SIZE))
                                       : RING_AW'(rb_raw);
    assign rowb_sum  = (RING_AW+1)'(r_rowb) + (RING_AW+1)'(i_w);
    assign rowb_next = (rowb_sum >= (RING_AW+1)'(RING_SIZE))
                       ? RING_AW'(rowb_sum - (RING_AW+1)'(RING_SIZE)) : RING_AW'(rowb_sum);
    assign addr_next = (r_raddr == RING_AW'(RING_SIZE - 1)) ? '0 : r_raddr + 1'b1;
    assign two_r     = DC_W'({i_rad, 1'b0});

    assign prod = (X_W+RECIP_W)'(r_x) * (X_W+RECIP_W)'(RECIP);

    assign sum_old[0] = r_hdata.sum_r;
    assign sum_old[1] = r_hdata.sum_g;
    assign sum_old[2] = r_hdata.sum_b;
    assign cnt_new    = (r_hv ? r_hdata.cnt : '0) + 1'b1;

    always_comb begin
        for (int c = 0; c < NCOL; c++) begin
            sum_new[c] = (r_hv ? sum_old[c] : '0) +
                         SUM_W'(r_rgb[(NCOL-1-c)*COLOR_W +: COLOR_W]);
            trial[c]   = {r_rem[c], r_divd[c][SUM_W-1]};
            ge[c]      = trial[c] >= (CNT_W+1)'(r_best_cnt);
        end
    end

    assign take_best = (cnt_new > r_best_cnt) ||
                       ((cnt_new == r_best_cnt) && (r_inten < r_best_int));

    assign o_stat.emit     = emit;
    assign o_stat.interior = interior;
    assign o_stat.win_last = (r_dc == two_r) && (r_dr == two_r);
    assign o_stat.div_last = (r_dcnt == DCNT_W'(DIV_STEPS - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Line ring: written on each accepted pixel, read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_kind) begin
            r_ring[r_wp] <= {i_red, i_green, i_blue};
        end
        r_rdata <= r_ring[r_raddr];
    end

    // Histogram: one entry per intensity holding count and color sums.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hwr) begin
            r_hist[r_inten] <= '{cnt: cnt_new, sum_r: sum_new[0], sum_g: sum_new[1],
                                 sum_b: sum_new[2]};
        end
        r_hdata <= r_hist[r_inten];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
            r_hv     <= 1'b0;
        end else begin
            r_hv <= r_hvalid[r_inten];
            if (i_cmd.wstart) begin
                r_hvalid <= '0;
            end else if (i_cmd.hwr) begin
                r_hvalid[r_inten] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_held      <= '0;
            r_ocol      <= '0;
            r_orow      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_wp   <= '0;
                r_held <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else if (i_cmd.accept) begin
                if (!i_kind) begin
                    r_wp   <= (r_wp == RING_AW'(RING_SIZE - 1)) ? '0 : r_wp + 1'b1;
                    r_held <= LAG_W'(held_inc - (LAG_W+1)'(emit));
                end else begin
                    r_held <= r_held - LAG_W'(emit);
                end
                if (emit) begin
                    if (col_inc >= i_w) begin
                        r_ocol <= '0;
                        r_orow <= (row_inc >= (FH_W+1)'(i_h)) ? '0 : FH_W'(row_inc);
                    end else begin
                        r_ocol <= COL_W'(col_inc);
                    end
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && emit) begin
            r_raddr  <= pos;
            r_border <= !interior;
            r_fend   <= fend;
        end
        if (i_cmd.wstart) begin
            r_raddr    <= rb;
            r_rowb     <= rb;
            r_dc       <= '0;
            r_dr       <= '0;
            r_best_cnt <= '0;
            r_best_int <= '0;
        end
        if (i_cmd.pint) begin
            r_rgb <= r_rdata;
            r_x   <= X_W'(K_R) * X_W'(r_rdata[2*COLOR_W +: COLOR_W]) +
                     X_W'(K_G) * X_W'(r_rdata[COLOR_W +: COLOR_W]) +
                     X_W'(K_B) * X_W'(r_rdata[0 +: COLOR_W]);
        end
        if (i_cmd.pdiv) begin
            r_inten <= prod[RECIP_SH +: INT_W];
        end
        if (i_cmd.hwr) begin
            if (take_best) begin
                r_best_cnt <= cnt_new;
                r_best_int <= r_inten;
                for (int c = 0; c < NCOL; c++) begin
                    r_best_sum[c] <= sum_new[c];
                end
            end
            if (r_dc == two_r) begin
                r_dc    <= '0;
                r_dr    <= r_dr + 1'b1;
                r_rowb  <= rowb_next;
                r_raddr <= rowb_next;
            end else begin
                r_dc    <= r_dc + 1'b1;
                r_raddr <= addr_next;
            end
        end
        if (i_cmd.dstart) begin
            r_dcnt <= '0;
            for (int c = 0; c < NCOL; c++) begin
                r_divd[c] <= r_best_sum[c];
                r_rem[c]  <= '0;
            end
        end
        if (i_cmd.dstep) begin
            r_dcnt <= r_dcnt + 1'b1;
            for (int c = 0; c < NCOL; c++) begin
                r_rem[c]  <= ge[c] ? CNT_W'(trial[c] - (CNT_W+1)'(r_best_cnt))
                                   : CNT_W'(trial[c]);
                r_divd[c] <= {r_divd[c][SUM_W-2:0], ge[c]};
            end
        end
        if (i_cmd.load) begin
            r_out_fend <= r_fend;
            for (int c = 0; c < NCOL; c++) begin
                r_out_col[c] <= r_border ? r_rdata[(NCOL-1-c)*COLOR_W +: COLOR_W]
                                         : r_divd[c][COLOR_W-1:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_col[0];
    assign o_green     = r_out_col[1];
    assign o_blue      = r_out_col[2];
    assign o_fend      = r_out_fend;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= lag)
        else $error("held pixel count exceeds output lag");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dstart |-> r_best_cnt != '0)
        else $error("division started with zero mode count");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !r_border) |-> r_divd[0][SUM_W-1:COLOR_W] == '0)
        else $error("red mean exceeds color range");

endmodule

// ----- test/tb_oil_paint_histogram_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_oil_paint_histogram_filter
// Self-checking bench for the oil-paint histogram filter.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own line ring, frame position and registers,
// and predicts each filtered pixel as input items are accepted. Directed
// frames cover color extremes, flushes and register extremes; random frames
// of small sizes follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_oil_paint_histogram_filter;
    import ophf_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_pixel_out;

    class oil_scoreboard;
        logic [PIX_W-1:0] ring [RING_SIZE];
        int unsigned      width_reg;
        int unsigned      height_reg;
        int unsigned      radius_reg;
        int unsigned      wr_ptr;
        int unsigned      held_cnt;
        int unsigned      out_col;
        int unsigned      out_row;
        t_pixel_out       pending_q [$];
        int               errors;

        function new();
            width_reg  = 640;
            height_reg = 480;
            radius_reg = 2;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            wr_ptr   = 0;
            held_cnt = 0;
            out_col  = 0;
            out_row  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_WIDTH:  width_reg  = value[10:0];
                REG_HEIGHT: height_reg = value[15:0];
                REG_RADIUS: radius_reg = value[1:0];
                default: return;
            endcase
            restart();
        endfunction

        function logic [PIX_W-1:0] ring_read(int base, int offset);
            int idx;
            idx = (base + offset) % RING_SIZE;
            if (idx < 0) idx += RING_SIZE;
            return ring[idx];
        endfunction

        function logic [PIX_W-1:0] paint(int pos, int w, int r);
            int unsigned counts [256];
            int unsigned sum_r [256];
            int unsigned sum_g [256];
            int unsigned sum_b [256];
            int unsigned inten, top_cnt, top_int;
            logic [PIX_W-1:0] p;
            logic [7:0] mr, mg, mb;
            for (int t = 0; t < 256; t++) begin
                counts[t] = 0;
                sum_r[t]  = 0;
                sum_g[t]  = 0;
                sum_b[t]  = 0;
            end
            for (int dr = -r; dr <= r; dr++) begin
                for (int dc = -r; dc <= r; dc++) begin
                    p = ring_read(pos, dr * w + dc);
                    inten = (21 * p[23:16] + 72 * p[15:8] + 7 * p[7:0]) / 100;
                    if (inten > 255) inten = 255;
                    counts[inten]++;
                    sum_r[inten] += p[23:16];
                    sum_g[inten] += p[15:8];
                    sum_b[inten] += p[7:0];
                end
            end
            top_cnt = 0;
            top_int = 0;
            for (int t = 0; t < 256; t++) begin
                if (counts[t] > top_cnt) begin
                    top_cnt = counts[t];
                    top_int = t;
                end
            end
            mr = 8'(sum_r[top_int] / top_cnt);
            mg = 8'(sum_g[top_int] / top_cnt);
            mb = 8'(sum_b[top_int] / top_cnt);
            return {mr, mg, mb};
        endfunction

        function void note_input(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned w, h, rad, lag;
            int pos;
            bit emit;
            logic [PIX_W-1:0] pix;
            t_pixel_out res;
            w   = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
            h   = (height_reg == 0) ? 1 : height_reg;
            rad = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
            lag = rad * w + rad;
            if (!kind) begin
                ring[wr_ptr] = {r, g, b};
                wr_ptr = (wr_ptr + 1) % RING_SIZE;
                held_cnt++;
                emit = held_cnt > lag;
            end else begin
                emit = held_cnt > 0;
            end
            if (!emit) return;
            pos = (wr_ptr + RING_SIZE - held_cnt) % RING_SIZE;
            if (out_col >= rad && out_col + rad < w && out_row >= rad && out_row + rad < h)
                pix = paint(pos, w, rad);
            else
                pix = ring[pos];
            held_cnt--;
            res.red       = pix[23:16];
            res.green     = pix[15:8];
            res.blue      = pix[7:0];
            res.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
            pending_q.push_back(res);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
                if (out_row >= h) out_row = 0;
            end
        endfunction

        function void check_result(t_pixel_out got);
            t_pixel_out want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red expected %h actual %h", $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green expected %h actual %h", $time, want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %b actual %b", $time,
                         want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ophf_in_if  pix_in ();
    ophf_out_if pix_out ();

    oil_paint_histogram_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_in.sink),
        .o_pix   (pix_out.source)
    );

    oil_scoreboard sb = new();
    int unsigned   send_idle;
    int unsigned   recv_idle;
    int unsigned   sent_items;
    logic [PIX_W-1:0] palette [4];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready)
            sb.check_result({pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                             pix_out.frame_end});
        pix_out.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic wait_drained();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(logic [31:0] w, logic [31:0] h, logic [31:0] r);
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_RADIUS, r);
    endtask

    task automatic send_item(logic kind, logic [PIX_W-1:0] p);
        while ($urandom_range(99) < send_idle) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.kind     <= kind;
        pix_in.red_in   <= p[23:16];
        pix_in.green_in <= p[15:8];
        pix_in.blue_in  <= p[7:0];
        do @(posedge i_clk); while (!pix_in.ready);
        sb.note_input(kind, p[23:16], p[15:8], p[7:0]);
        sent_items++;
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        if ($urandom_range(1) == 0) return palette[$urandom_range(3)];
        return PIX_W'($urandom);
    endfunction

    task automatic send_pixels_and_drain(int n, int flushes);
        for (int i = 0; i < n; i++) send_item(1'b0, rand_pixel());
        for (int i = 0; i < flushes; i++) send_item(1'b1, PIX_W'($urandom));
    endtask

    initial begin
        int w, h, r, n;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix_in.valid    = 1'b0;
        pix_in.kind     = 1'b0;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        send_idle       = 19;
        recv_idle       = 68;
        sent_items      = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(1'b1, 24'h000000);
        send_item(1'b0, 24'h000000);
        send_item(1'b0, 24'hFFFFFF);
        send_item(1'b0, 24'hFF0000);
        send_item(1'b0, 24'h00FF00);
        send_item(1'b0, 24'h0000FF);
        for (int i = 0; i < 6; i++) send_item(1'b1, 24'hFFFFFF);

        set_frame(5, 5, 2);
        for (int i = 0; i < 25; i++)
            send_item(1'b0, (i % 2) ? 24'h646464 : ((i % 3) ? 24'h0A0A0A : 24'hC81E50));
        send_item(1'b1, 24'h0);
        set_frame(0, 0, 0);
        send_pixels_and_drain(4, 2);
        set_frame(2047, 65535, 3);
        send_pixels_and_drain(20, 22);
        set_frame(1024, 2, 1);
        send_pixels_and_drain(10, 12);
        set_frame(7, 7, 3);
        send_pixels_and_drain(49, 30);

        while (sent_items < 1650) begin
            if (sent_items < 560) begin
                send_idle = 19;
                recv_idle = 68;
            end else if (sent_items < 1110) begin
                send_idle = 68;
                recv_idle = 19;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int k = 0; k < 4; k++) palette[k] = PIX_W'($urandom);
            w = $urandom_range(12, 1);
            h = $urandom_range(8, 1);
            r = $urandom_range(3);
            set_frame(w, h, r);
            n = $urandom_range(2 * w * h + 1, 1);
            if (n > 150) n = 150;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(19) == 0) send_item(1'b1, PIX_W'($urandom));
                else send_item(1'b0, rand_pixel());
                if (i == n / 2 && $urandom_range(7) == 0) begin
                    pix_in.valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.pending_q.size() != 0) @(posedge i_clk);
                end
            end
            if ($urandom_range(3) != 0)
                for (int i = 0; i < r * w + r + 2; i++) send_item(1'b1, PIX_W'($urandom));
        end

        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/ophf_pkg.sv
hdl/ophf_in_if.sv
hdl/ophf_out_if.sv
hdl/ophf_ctrl.sv
hdl/ophf_dpath.sv
hdl/oil_paint_histogram_filter.sv
test/tb_oil_paint_histogram_filter.sv
